/* hdl/gtb_pkg.sv */
// Package for the greedy tour builder: default sizes, command codes,
// result record and the saturating cost adder.
// No dependencies.
`timescale 1ns / 1ps

package gtb_pkg;

  localparam int MAX_CITIES_DEF  = 32;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int CITY_BITS       = 5;
  localparam int COUNT_BITS      = 6;
  localparam int COST_BITS       = 21;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
  localparam logic [0:0] REG_CITY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_GREEDY = 2'd1,
    CMD_EVAL   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CITY_BITS-1:0] city;
    logic [COST_BITS-1:0] cost;
    logic                 cost_valid;
    logic                 last;
  } result_t;

  // Add one weight to a cost and clip at the largest cost.
  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] acc,
                                                   input logic [31:0] w);
    logic [32:0] s;
    s = 33'(acc) + 33'(w);
    return (s > 33'(COST_MAX)) ? COST_MAX : s[COST_BITS-1:0];
  endfunction

endpackage

/* hdl/gtb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module gtb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/greedy_tour_builder_and_cost.sv */
// Top level of the greedy tour builder and tour cost unit.
// Depends on gtb_pkg and gtb_ram (cost matrix storage).
`timescale 1ns / 1ps

// The cost matrix lives in one RAM with registered read data, and a greedy
// row scan fetches one entry per cycle. An evaluate beat that closes the
// tour does one extra read, of the closing edge back to the first city. A
// greedy command with n cities scans one matrix row per step, input held off
// all the while. A result waits while the output register is still full.
// Matrix entries have no reset and must be loaded before a tour uses them.
module greedy_tour_builder_and_cost import gtb_pkg::*; #(
  parameter int MAX_CITIES  = MAX_CITIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row_city, col_city, weight, tour_city, zero pad
  input  logic [1:0]  s_axis_tuser,  // command
  input  logic        s_axis_tlast,  // tour_last
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_city, tour_cost, zero pad
  output logic        m_axis_tuser,  // cost_valid
  output logic        m_axis_tlast   // last
);

  localparam int CB    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CNTW  = $clog2(MAX_CITIES + 1);
  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EADD   = 4'd1;
  localparam logic [3:0] S_ECLOSE = 4'd2;
  localparam logic [3:0] S_GEMIT  = 4'd3;
  localparam logic [3:0] S_GSCAN  = 4'd4;
  localparam logic [3:0] S_GNEXT  = 4'd5;
  localparam logic [3:0] S_GCLOSE = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;

  function automatic logic [AW-1:0] mat_addr(input int r, input int c);
    return AW'(r * MAX_CITIES + c);
  endfunction

  // input fields
  logic [CITY_BITS-1:0] row_city, col_city, tour_city;
  logic [15:0]          weight;
  cmd_e                 command;
  logic                 in_acc;

  assign row_city  = s_axis_tdata[4:0];
  assign col_city  = s_axis_tdata[9:5];
  assign weight    = s_axis_tdata[25:10];
  assign tour_city = s_axis_tdata[30:26];
  assign command   = cmd_e'(s_axis_tuser);

  // control state
  logic [3:0]            state_q, state_d, ret_q, ret_d;
  logic [COUNT_BITS-1:0] city_count_q;
  logic [MAX_CITIES-1:0] visited_q, visited_d;
  logic [CITY_BITS-1:0]  first_q, first_d, prev_q, prev_d;
  logic [COST_BITS-1:0]  running_q, running_d;
  logic                  started_q, started_d;
  logic [CNTW-1:0]       step_q, step_d, issue_q, issue_d;
  logic                  rd_v_q, rd_v_d, found_q, found_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  logic [CNTW-1:0]        n_q, n_d, n_eff;
  logic [CB-1:0]          cur_q, cur_d, start_q, start_d, pick_q, pick_d, rd_j_q, rd_j_d;
  logic [CB-1:0]          start_sel;
  logic [WEIGHT_BITS-1:0] best_q, best_d;
  logic [COST_BITS-1:0]   total_q, total_d;
  logic [CITY_BITS-1:0]   tc_q, tc_d;
  logic                   tl_q, tl_d, add_q, add_d, ok_q, ok_d;
  result_t                res_q, res_d, out_q, out_d;

  // matrix RAM
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_wdata, mem_rdata;
  logic [31:0]            edge_w;

  gtb_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign edge_w = 32'(mem_rdata);

  // configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CITY_COUNT);
  assign prdata = (paddr[2] == REG_CITY_COUNT) ? 32'(city_count_q) : '0;

  // clamp the city count to the usable range
  always_comb begin
    int cc;
    cc = int'(city_count_q);
    if (cc < 2) begin
      n_eff = CNTW'(2);
    end else if (cc > MAX_CITIES) begin
      n_eff = CNTW'(MAX_CITIES);
    end else begin
      n_eff = CNTW'(cc);
    end
  end

  assign start_sel     = (int'(row_city) < int'(n_eff)) ? CB'(row_city) : '0;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    visited_d   = visited_q;
    first_d     = first_q;
    prev_d      = prev_q;
    running_d   = running_q;
    started_d   = started_q;
    step_d      = step_q;
    issue_d     = issue_q;
    rd_v_d      = 1'b0;
    found_d     = found_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    n_d         = n_q;
    cur_d       = cur_q;
    start_d     = start_q;
    pick_d      = pick_q;
    rd_j_d      = rd_j_q;
    best_d      = best_q;
    total_d     = total_q;
    tc_d        = tc_q;
    tl_d        = tl_q;
    add_d       = add_q;
    ok_d        = ok_q;
    res_d       = res_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = mat_addr(int'(row_city), int'(col_city));
    mem_wdata   = WEIGHT_BITS'(weight);
    mem_re      = 1'b0;
    mem_raddr   = mat_addr(int'(prev_q), int'(tour_city));

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (command)
            CMD_LOAD: begin
              if (int'(row_city) < MAX_CITIES && int'(col_city) < MAX_CITIES) begin
                mem_we = 1'b1;
              end
            end
            CMD_GREEDY: begin
              started_d            = 1'b0;
              running_d            = '0;
              cur_d                = start_sel;
              start_d              = start_sel;
              visited_d            = '0;
              visited_d[start_sel] = 1'b1;
              n_d                  = n_eff;
              step_d               = CNTW'(1);
              total_d              = '0;
              state_d              = S_GEMIT;
            end
            CMD_EVAL: begin
              tc_d   = tour_city;
              tl_d   = s_axis_tlast;
              mem_re = 1'b1;
              ok_d   = (int'(prev_q) < MAX_CITIES) && (int'(tour_city) < MAX_CITIES);
              if (!started_q) begin
                first_d   = tour_city;
                running_d = '0;
                started_d = 1'b1;
                add_d     = 1'b0;
              end else begin
                add_d = 1'b1;
              end
              prev_d  = tour_city;
              state_d = S_EADD;
            end
            default: ;
          endcase
        end
      end

      S_EADD: begin
        if (add_q) begin
          running_d = sat_add(running_q, ok_q ? edge_w : 32'd0);
        end
        if (tl_q) begin
          // fetch the closing edge back to the first city
          mem_re    = 1'b1;
          mem_raddr = mat_addr(int'(tc_q), int'(first_q));
          ok_d      = (int'(tc_q) < MAX_CITIES) && (int'(first_q) < MAX_CITIES);
          state_d   = S_ECLOSE;
        end else begin
          res_d   = '{city: tc_q, cost: '0, cost_valid: 1'b0, last: 1'b1};
          ret_d   = S_IDLE;
          state_d = S_PUSH;
        end
      end

      S_ECLOSE: begin
        res_d     = '{city: tc_q, cost: sat_add(running_q, ok_q ? edge_w : 32'd0),
                      cost_valid: 1'b1, last: 1'b1};
        running_d = '0;
        started_d = 1'b0;
        ret_d     = S_IDLE;
        state_d   = S_PUSH;
      end

      S_GEMIT: begin
        res_d   = '{city: CITY_BITS'(cur_q), cost: '0, cost_valid: 1'b0, last: 1'b0};
        issue_d = '0;
        found_d = 1'b0;
        ret_d   = S_GSCAN;
        state_d = S_PUSH;
      end

      S_GSCAN: begin
        if (issue_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = mat_addr(int'(cur_q), int'(issue_q));
          issue_d   = issue_q + CNTW'(1);
          rd_v_d    = 1'b1;
          rd_j_d    = CB'(issue_q);
        end
        // compare the entry that came back from the previous read
        if (rd_v_q) begin
          if (!visited_q[rd_j_q] && (!found_q || mem_rdata < best_q)) begin
            found_d = 1'b1;
            best_d  = mem_rdata;
            pick_d  = rd_j_q;
          end
          if (int'(rd_j_q) == int'(n_q) - 1) begin
            state_d = S_GNEXT;
          end
        end
      end

      S_GNEXT: begin
        visited_d[pick_q] = 1'b1;
        total_d           = sat_add(total_q, 32'(best_q));
        cur_d             = pick_q;
        if (int'(step_q) == int'(n_q) - 1) begin
          mem_re    = 1'b1;
          mem_raddr = mat_addr(int'(pick_q), int'(start_q));
          state_d   = S_GCLOSE;
        end else begin
          step_d  = step_q + CNTW'(1);
          state_d = S_GEMIT;
        end
      end

      S_GCLOSE: begin
        res_d   = '{city: CITY_BITS'(cur_q), cost: sat_add(total_q, edge_w),
                    cost_valid: 1'b1, last: 1'b1};
        ret_d   = S_IDLE;
        state_d = S_PUSH;
      end

      S_PUSH: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      city_count_q <= COUNT_BITS'(32);
      visited_q    <= '0;
      first_q      <= '0;
      prev_q       <= '0;
      running_q    <= '0;
      started_q    <= 1'b0;
      step_q       <= '0;
      issue_q      <= '0;
      rd_v_q       <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      if (cfg_we) begin
        city_count_q <= pwdata[COUNT_BITS-1:0];
      end
      visited_q   <= visited_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      running_q   <= running_d;
      started_q   <= started_d;
      step_q      <= step_d;
      issue_q     <= issue_d;
      rd_v_q      <= rd_v_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    cur_q   <= cur_d;
    start_q <= start_d;
    pick_q  <= pick_d;
    rd_j_q  <= rd_j_d;
    best_q  <= best_d;
    total_q <= total_d;
    tc_q    <= tc_d;
    tl_q    <= tl_d;
    add_q   <= add_d;
    ok_q    <= ok_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.cost, out_q.city};
  assign m_axis_tuser  = out_q.cost_valid;
  assign m_axis_tlast  = out_q.last;

  // one city marked visited per finished step
  a_visited_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GSCAN) |-> ($countones(visited_q) == int'(step_q)))
    else $error("visited count does not match the tour step");

  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GSCAN && rd_v_q) |-> (int'(rd_j_q) < int'(n_q)))
    else $error("row scan ran past the city count");

  a_cost_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("finished cost on a beat that is not last");

  a_ram_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("matrix read and write in the same cycle");

endmodule

/* tb/sv/greedy_tour_builder_and_cost_test.sv */
// Self-checking bench for greedy_tour_builder_and_cost: fills the cost matrix, walks
// a directed table, then runs random phases of loads, greedy tours and evaluated
// tours, each result beat checked against a behavioural cost model. Needs gtb_pkg.
`timescale 1ns / 1ps

module greedy_tour_builder_and_cost_test;
  import gtb_pkg::*;

  localparam int         NCITY       = MAX_CITIES_DEF;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [2:0] CFG_ADDR    = {REG_CITY_COUNT, 2'b00};
  localparam int         QUIET_LIMIT = 6000;
  localparam int         RAND_ITEMS  = 120;

  typedef struct {
    logic [1:0]           cmd;
    logic [CITY_BITS-1:0] row;
    logic [CITY_BITS-1:0] col;
    logic [15:0]          weight;
    logic [CITY_BITS-1:0] tcity;
    logic                 tlast;
  } beat_t;

  typedef struct {
    bit                   cfg;     // write weight[5:0] to city_count, send no beat
    logic [1:0]           cmd;
    logic [CITY_BITS-1:0] row;
    logic [CITY_BITS-1:0] col;
    logic [15:0]          weight;
    logic [CITY_BITS-1:0] tcity;
    logic                 tlast;
    bit                   typed;   // expected result given below
    logic [CITY_BITS-1:0] e_city;
    logic [COST_BITS-1:0] e_cost;
    logic                 e_valid;
    logic                 e_last;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser, m_axis_tlast;

  greedy_tour_builder_and_cost dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tour model state
  logic [15:0]          cost_mx [NCITY][NCITY];
  logic [COUNT_BITS-1:0] count_reg;
  logic [NCITY-1:0]     seen;
  logic [CITY_BITS-1:0] tour_head, tour_prev;
  logic [COST_BITS-1:0] tour_run;
  logic                 tour_open;
  result_t              tour_results_due[$];

  bit idle_on;
  int quiet, errors, stall_left;
  int n_loads, n_tours, n_evals, n_closed, n_results, n_settings;

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(3))
      0: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      1: return 16'($urandom_range(7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t make_beat(logic [1:0] cmd, logic [4:0] row, logic [4:0] col,
                                     logic [15:0] w, logic [4:0] tc, logic tl);
    beat_t b;
    b.cmd = cmd;
    b.row = row;
    b.col = col;
    b.weight = w;
    b.tcity = tc;
    b.tlast = tl;
    return b;
  endfunction

  function automatic logic [COST_BITS-1:0] clip_add(logic [COST_BITS-1:0] acc, logic [15:0] w);
    logic [COST_BITS:0] s;
    s = {1'b0, acc} + (COST_BITS + 1)'(w);
    return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_BITS-1:0];
  endfunction

  function automatic int active_cities();
    if (count_reg < 2) return 2;
    if (count_reg > NCITY) return NCITY;
    return int'(count_reg);
  endfunction

  function automatic void push_result(logic [4:0] city, logic [COST_BITS-1:0] cost,
                                      logic valid, logic lst);
    result_t r;
    r.city = city;
    r.cost = cost;
    r.cost_valid = valid;
    r.last = lst;
    tour_results_due.insert(tour_results_due.size(), r);
  endfunction

  // Advance the model by one accepted beat and queue the results it causes.
  function automatic void predict_tour_results(beat_t b);
    int n, i, j;
    logic [CITY_BITS-1:0] cur, start, pick;
    logic [15:0] best;
    logic found;
    logic [COST_BITS-1:0] total;
    case (b.cmd)
      CMD_LOAD: begin
        cost_mx[b.row][b.col] = b.weight;
        n_loads++;
      end
      CMD_GREEDY: begin
        n = active_cities();
        cur = (b.row < n) ? b.row : '0;
        start = cur;
        total = '0;
        tour_open = 1'b0;
        tour_run = '0;
        seen = '0;
        seen[cur] = 1'b1;
        for (i = 1; i < n; i++) begin
          push_result(cur, '0, 1'b0, 1'b0);
          found = 1'b0;
          best = '0;
          pick = '0;
          for (j = 0; j < n; j++) begin
            if (seen[j]) continue;
            if (!found || cost_mx[cur][j] < best) begin
              found = 1'b1;
              best = cost_mx[cur][j];
              pick = 5'(j);
            end
          end
          seen[pick] = 1'b1;
          total = clip_add(total, best);
          cur = pick;
        end
        total = clip_add(total, cost_mx[cur][start]);
        push_result(cur, total, 1'b1, 1'b1);
        n_tours++;
      end
      CMD_EVAL: begin
        if (!tour_open) begin
          tour_head = b.tcity;
          tour_run = '0;
          tour_open = 1'b1;
        end else begin
          tour_run = clip_add(tour_run, cost_mx[tour_prev][b.tcity]);
        end
        tour_prev = b.tcity;
        total = '0;
        if (b.tlast) begin
          total = clip_add(tour_run, cost_mx[b.tcity][tour_head]);
          tour_open = 1'b0;
          tour_run = '0;
          n_closed++;
        end
        push_result(b.tcity, total, b.tlast, 1'b1);
        n_evals++;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 30)
      $display("%0t: mismatch in %s at result %0d: expected %0h, got %0h",
               $time, what, n_results, want, got);
  endtask

  task automatic send_beat(beat_t b, bit typed, result_t typed_res);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, b.tcity, b.weight, b.col, b.row};
    s_axis_tuser  <= b.cmd;
    s_axis_tlast  <= b.tlast;
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    predict_tour_results(b);
    if (typed) begin
      void'(tour_results_due.pop_back());
      tour_results_due.insert(tour_results_due.size(), typed_res);
    end
  endtask

  // Hold input until every queued result has left, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tour_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic read_count(logic [COUNT_BITS-1:0] want);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(want)) flag_mismatch("city_count readback", 32'(want), rd);
  endtask

  task automatic set_count(logic [COUNT_BITS-1:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    count_reg = val;
    read_count(val);
    n_settings++;
  endtask

  // Result side: random back-pressure, stretches of it long.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = idle_gap();
      m_axis_tready <= 1'b1;
    end
  end

  // Sample at the falling edge: everything is stable until the next rising edge.
  always @(negedge clk_i) begin
    result_t got, want;
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got.city = m_axis_tdata[4:0];
        got.cost = m_axis_tdata[25:5];
        got.cost_valid = m_axis_tuser;
        got.last = m_axis_tlast;
        n_results++;
        if (tour_results_due.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, m_axis_tdata);
        end else begin
          want = tour_results_due.pop_front();
          if (got.city !== want.city) flag_mismatch("out_city", 32'(want.city), 32'(got.city));
          if (got.cost !== want.cost) flag_mismatch("tour_cost", 32'(want.cost), 32'(got.cost));
          if (got.cost_valid !== want.cost_valid)
            flag_mismatch("cost_valid", 32'(want.cost_valid), 32'(got.cost_valid));
          if (got.last !== want.last) flag_mismatch("last", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) @(negedge clk_i);
    $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  plan_row_t plan[25];

  initial begin
    plan_row_t r;
    result_t   tr;
    int items, quota, k, len, n, sel, phase;
    bit broken, paused;
    logic [COUNT_BITS-1:0] cnt;
    logic [CITY_BITS-1:0] tc;

    // cfg cmd row col weight tcity tlast | typed city cost valid last
    plan = '{
      '{0, CMD_LOAD,    5'd3,  5'd3,  16'hFFFF, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      // a tour whose first city is marked last closes on itself
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd3,  1'b1, 1, 5'd3,  21'd65535, 1'b1, 1'b1},
      '{0, CMD_LOAD,    5'd0,  5'd31, 16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_LOAD,    5'd31, 5'd0,  16'hFFFF, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd0,  1'b0, 1, 5'd0,  21'd0,     1'b0, 1'b1},
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd31, 1'b1, 1, 5'd31, 21'd65535, 1'b1, 1'b1},
      // unknown command: nothing happens
      '{0, CMD_UNKNOWN, 5'd31, 5'd31, 16'hFFFF, 5'd31, 1'b1, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_EVAL,    5'd31, 5'd31, 16'hFFFF, 5'd31, 1'b0, 1, 5'd31, 21'd0,     1'b0, 1'b1},
      // greedy drops the half-evaluated tour
      '{0, CMD_GREEDY,  5'd5,  5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_LOAD,    5'd0,  5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd0,  1'b1, 1, 5'd0,  21'd0,     1'b1, 1'b1},
      '{0, CMD_GREEDY,  5'd31, 5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_LOAD,    5'd31, 5'd31, 16'hFFFF, 5'd31, 1'b1, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      // count below two acts as two
      '{1, CMD_LOAD,    5'd0,  5'd0,  16'd0,    5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_GREEDY,  5'd1,  5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      // start outside the count falls back to city 0
      '{0, CMD_GREEDY,  5'd31, 5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{1, CMD_LOAD,    5'd0,  5'd0,  16'd1,    5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_GREEDY,  5'd0,  5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      // count above the matrix acts as the full matrix
      '{1, CMD_LOAD,    5'd0,  5'd0,  16'd63,   5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_GREEDY,  5'd17, 5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{1, CMD_LOAD,    5'd0,  5'd0,  16'd33,   5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd31, 1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_EVAL,    5'd0,  5'd0,  16'h0000, 5'd30, 1'b1, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{1, CMD_LOAD,    5'd0,  5'd0,  16'd2,    5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0},
      '{0, CMD_GREEDY,  5'd1,  5'd0,  16'h0000, 5'd0,  1'b0, 0, 5'd0,  21'd0,     1'b0, 1'b0}
    };

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    count_reg = 6'd32;
    seen      = '0;
    tour_head = '0;
    tour_prev = '0;
    tour_run  = '0;
    tour_open = 1'b0;
    tr        = '0;
    idle_on   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_count(6'd32);

    // Write every entry first so that no tour ever reads an unwritten one.
    for (int row = 0; row < NCITY; row++)
      for (int col = 0; col < NCITY; col++)
        send_beat(make_beat(CMD_LOAD, 5'(row), 5'(col), pick_weight(),
                            5'($urandom_range(31)), 1'($urandom_range(1))), 0, tr);

    idle_on = 1'b1;
    foreach (plan[i]) begin
      r = plan[i];
      if (r.cfg) begin
        set_count(r.weight[COUNT_BITS-1:0]);
      end else begin
        tr.city = r.e_city;
        tr.cost = r.e_cost;
        tr.cost_valid = r.e_valid;
        tr.last = r.e_last;
        send_beat(make_beat(r.cmd, r.row, r.col, r.weight, r.tcity, r.tlast), r.typed, tr);
      end
    end

    // Long tour over two all-ones edges: the running cost saturates.
    set_count(6'd32);
    send_beat(make_beat(CMD_LOAD, 5'd30, 5'd31, 16'hFFFF, 5'd0, 1'b0), 0, tr);
    send_beat(make_beat(CMD_LOAD, 5'd31, 5'd30, 16'hFFFF, 5'd0, 1'b0), 0, tr);
    for (k = 0; k < 36; k++)
      send_beat(make_beat(CMD_EVAL, 5'($urandom_range(31)), 5'($urandom_range(31)),
                          16'($urandom), (k % 2 != 0) ? 5'd31 : 5'd30, k == 35), 0, tr);
    items = 38;

    phase = 0;
    while (items < RAND_ITEMS) begin
      sel = $urandom_range(9);
      if (sel < 6) cnt = 6'($urandom_range(6, 2));
      else if (sel < 8) cnt = 6'($urandom_range(16, 7));
      else if (sel == 8) cnt = 6'd32;
      else cnt = 6'($urandom_range(63));
      set_count(cnt);
      idle_on = ($urandom_range(3) != 0);
      n = active_cities();
      quota = items + $urandom_range(30, 15);
      paused = 1'b0;
      while (items < quota) begin
        if (!paused && items >= quota - 8) begin
          paused = 1'b1;
          if (phase == 0 || $urandom_range(2) == 0) wait_drained();
        end
        sel = $urandom_range(99);
        if (sel < 30) begin
          send_beat(make_beat(CMD_LOAD, 5'($urandom_range(31)), 5'($urandom_range(31)),
                              pick_weight(), 5'($urandom_range(31)), 1'($urandom_range(1))),
                    0, tr);
          items++;
        end else if (sel < 45) begin
          send_beat(make_beat(CMD_GREEDY, 5'($urandom_range(31)), 5'($urandom_range(31)),
                              16'($urandom), 5'($urandom_range(31)), 1'($urandom_range(1))),
                    0, tr);
          items++;
        end else if (sel < 50) begin
          send_beat(make_beat(CMD_UNKNOWN, 5'($urandom_range(31)), 5'($urandom_range(31)),
                              16'($urandom), 5'($urandom_range(31)), 1'($urandom_range(1))),
                    0, tr);
        end else begin
          // mostly complete tours; now and then leave one open
          len = $urandom_range(n + 1, 1);
          broken = ($urandom_range(6) == 0);
          for (k = 0; k < len; k++) begin
            tc = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(n - 1));
            send_beat(make_beat(CMD_EVAL, 5'($urandom_range(31)), 5'($urandom_range(31)),
                                16'($urandom), tc, (k == len - 1) && !broken), 0, tr);
            items++;
          end
        end
      end
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tour_results_due.size() != 0)
      flag_mismatch("results never delivered", '0, 32'(tour_results_due.size()));
    $display("covered %0d loads, %0d greedy tours, %0d evaluate beats, %0d closed tours",
             n_loads, n_tours, n_evals, n_closed);
    $display("checked %0d result beats over %0d city_count settings, %0d mismatches",
             n_results, n_settings, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/gtb_pkg.sv
hdl/gtb_ram.sv
hdl/greedy_tour_builder_and_cost.sv
tb/sv/greedy_tour_builder_and_cost_test.sv
